>>> rtl/ncl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncl_pkg
// Shared types and constants of the near-plane triangle clipper.
// ----------------------------------------------------------------------------
package ncl_pkg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vtx_t;

    typedef struct packed {
        vtx_t p0;
        vtx_t p1;
        vtx_t p2;
    } tri_t;

    typedef enum logic [1:0] {
        MODE_DROP,
        MODE_PASS,
        MODE_FRONT,
        MODE_BACK
    } mode_t;

    // Per-item data that bypasses the interpolators.
    typedef struct packed {
        mode_t       mode;
        vtx_t        q0;
        vtx_t        q1;
        vtx_t        q2;
        logic [31:0] color;
    } side_t;

    // One coordinate of one edge cut: n + sign * floor(mag * num / den).
    typedef struct packed {
        logic signed [31:0] n;
        logic               neg;
        logic [32:0]        mag;
        logic [32:0]        num;
        logic [32:0]        den;
    } lerp_in_t;

    localparam int DIV_STEPS = 33;
    localparam int LERP_LAT  = DIV_STEPS + 3;
    localparam int NUM_CUTS  = 4;

    localparam logic       ADDR_NEAR_Z  = 1'b0;
    localparam logic [31:0] NEAR_Z_RESET = 32'h0001_0000;

endpackage

>>> rtl/ncl_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncl_setup
// Front stages: input capture, side classification and edge set-up.
// ----------------------------------------------------------------------------
module ncl_setup
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  ncl_pkg::vtx_t                v0,
    input  ncl_pkg::vtx_t                v1,
    input  ncl_pkg::vtx_t                v2,
    input  logic [31:0]                  color,
    input  logic signed [31:0]           near_z,
    output logic                         vld,
    output ncl_pkg::side_t               side,
    output ncl_pkg::lerp_in_t [3:0]      cut
);
    import ncl_pkg::*;

    function automatic lerp_in_t edge_prep(input vtx_t a, input vtx_t b,
                                           input logic signed [31:0] nz,
                                           input logic ysel);
        vtx_t               n;
        vtx_t               m;
        logic signed [31:0] nc;
        logic signed [31:0] mc;
        logic        [32:0] d;
        lerp_in_t           r;
        n    = (a.z < b.z) ? a : b;
        m    = (a.z < b.z) ? b : a;
        nc   = ysel ? n.y : n.x;
        mc   = ysel ? m.y : m.x;
        d    = {mc[31], mc} - {nc[31], nc};
        r.n   = nc;
        r.neg = d[32];
        r.mag = d[32] ? (33'd0 - d) : d;
        r.num = {nz[31], nz} - {n.z[31], n.z};
        r.den = {m.z[31], m.z} - {n.z[31], n.z};
        return r;
    endfunction

    // Stage 1: captured item
    logic        s1_vld_reg;
    vtx_t        s1_v_reg [3];
    logic [31:0] s1_color_reg;

    // Stage 2: classified item
    logic        s2_vld_reg;
    side_t       s2_side_reg;
    vtx_t        s2_fa_reg, s2_fb_reg, s2_sa_reg, s2_sb_reg;
    side_t       s2_side_next;
    vtx_t        s2_fa_next, s2_fb_next, s2_sa_next, s2_sb_next;

    // Stage 3: edge set-up
    logic        s3_vld_reg;
    side_t       s3_side_reg;
    lerp_in_t [3:0] s3_cut_reg;

    logic [2:0]  bk;
    vtx_t        base, o1, o2;
    logic        base_bk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_v_reg[0]  <= v0;
            s1_v_reg[1]  <= v1;
            s1_v_reg[2]  <= v2;
            s1_color_reg <= color;
        end
        s2_side_reg <= s2_side_next;
        s2_fa_reg   <= s2_fa_next;
        s2_fb_reg   <= s2_fb_next;
        s2_sa_reg   <= s2_sa_next;
        s2_sb_reg   <= s2_sb_next;
        s3_side_reg <= s2_side_reg;
        s3_cut_reg[0] <= edge_prep(s2_fa_reg, s2_fb_reg, near_z, 1'b0);
        s3_cut_reg[1] <= edge_prep(s2_fa_reg, s2_fb_reg, near_z, 1'b1);
        s3_cut_reg[2] <= edge_prep(s2_sa_reg, s2_sb_reg, near_z, 1'b0);
        s3_cut_reg[3] <= edge_prep(s2_sa_reg, s2_sb_reg, near_z, 1'b1);
    end

    always_comb
    begin
        bk[0] = (s1_v_reg[0].z <= near_z);
        bk[1] = (s1_v_reg[1].z <= near_z);
        bk[2] = (s1_v_reg[2].z <= near_z);
        // The lone vertex is the one whose side differs from the other two.
        if (bk[1] == bk[2])
        begin
            base = s1_v_reg[0]; o1 = s1_v_reg[1]; o2 = s1_v_reg[2];
            s2_fa_next = s1_v_reg[0]; s2_fb_next = s1_v_reg[1];
            s2_sa_next = s1_v_reg[0]; s2_sb_next = s1_v_reg[2];
            base_bk = bk[0];
        end
        else if (bk[0] == bk[2])
        begin
            base = s1_v_reg[1]; o1 = s1_v_reg[0]; o2 = s1_v_reg[2];
            s2_fa_next = s1_v_reg[0]; s2_fb_next = s1_v_reg[1];
            s2_sa_next = s1_v_reg[1]; s2_sb_next = s1_v_reg[2];
            base_bk = bk[1];
        end
        else
        begin
            base = s1_v_reg[2]; o1 = s1_v_reg[0]; o2 = s1_v_reg[1];
            s2_fa_next = s1_v_reg[0]; s2_fb_next = s1_v_reg[2];
            s2_sa_next = s1_v_reg[1]; s2_sb_next = s1_v_reg[2];
            base_bk = bk[2];
        end

        s2_side_next.color = s1_color_reg;
        s2_side_next.q0    = s1_v_reg[0];
        if (bk[0] && bk[1] && bk[2])
        begin
            s2_side_next.mode = MODE_DROP;
            s2_side_next.q1   = s1_v_reg[1];
            s2_side_next.q2   = s1_v_reg[2];
        end
        else if ((bk[0] == bk[1]) && (bk[1] == bk[2]))
        begin
            s2_side_next.mode = MODE_PASS;
            s2_side_next.q1   = s1_v_reg[1];
            s2_side_next.q2   = s1_v_reg[2];
        end
        else if (base_bk)
        begin
            s2_side_next.mode = MODE_BACK;
            s2_side_next.q1   = o1;
            s2_side_next.q2   = o2;
        end
        else
        begin
            s2_side_next.mode = MODE_FRONT;
            s2_side_next.q1   = base;
            s2_side_next.q2   = o2;
        end
    end

    assign vld  = s3_vld_reg;
    assign side = s3_side_reg;
    assign cut  = s3_cut_reg;

endmodule

>>> rtl/ncl_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncl_lerp
// Pipelined cut coordinate: split product, restoring divide one quotient
// bit per stage, then sign, offset and saturation.
// ----------------------------------------------------------------------------
module ncl_lerp
(
    input  logic                  clk,
    input  ncl_pkg::lerp_in_t     din,
    output logic signed [31:0]    res
);
    import ncl_pkg::*;

    logic [49:0]        phi_reg;
    logic [48:0]        plo_reg;
    logic signed [31:0] n1_reg;
    logic               neg1_reg;
    logic [32:0]        den1_reg;

    logic [65:0]        prod_reg;
    logic signed [31:0] n2_reg;
    logic               neg2_reg;
    logic [32:0]        den2_reg;

    logic [32:0]        rem_reg  [DIV_STEPS];
    logic [32:0]        bits_reg [DIV_STEPS];
    logic [32:0]        quo_reg  [DIV_STEPS];
    logic [32:0]        dden_reg [DIV_STEPS];
    logic signed [31:0] dn_reg   [DIV_STEPS];
    logic               dneg_reg [DIV_STEPS];

    logic signed [31:0] res_reg;

    logic [33:0]        sum;
    logic [32:0]        q;

    always_ff @(posedge clk)
    begin
        phi_reg  <= din.mag * din.num[32:16];
        plo_reg  <= din.mag * din.num[15:0];
        n1_reg   <= din.n;
        neg1_reg <= din.neg;
        den1_reg <= din.den;

        prod_reg <= {phi_reg, 16'd0} + {17'd0, plo_reg};
        n2_reg   <= n1_reg;
        neg2_reg <= neg1_reg;
        den2_reg <= den1_reg;
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_div
            logic [32:0]        r_in, b_in, q_in, d_in;
            logic signed [31:0] n_in;
            logic               neg_in;
            logic [33:0]        t;
            logic [33:0]        diff;
            logic               ge;

            if (k == 0)
            begin : g_first
                assign r_in   = prod_reg[65:33];
                assign b_in   = prod_reg[32:0];
                assign q_in   = '0;
                assign d_in   = den2_reg;
                assign n_in   = n2_reg;
                assign neg_in = neg2_reg;
            end
            else
            begin : g_next
                assign r_in   = rem_reg[k-1];
                assign b_in   = bits_reg[k-1];
                assign q_in   = quo_reg[k-1];
                assign d_in   = dden_reg[k-1];
                assign n_in   = dn_reg[k-1];
                assign neg_in = dneg_reg[k-1];
            end

            assign t    = {r_in, b_in[32]};
            assign diff = t - {1'b0, d_in};
            assign ge   = (t >= {1'b0, d_in});

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= ge ? diff[32:0] : t[32:0];
                bits_reg[k] <= {b_in[31:0], 1'b0};
                quo_reg[k]  <= {q_in[31:0], ge};
                dden_reg[k] <= d_in;
                dn_reg[k]   <= n_in;
                dneg_reg[k] <= neg_in;
            end
        end
    endgenerate

    always_comb
    begin
        q   = quo_reg[DIV_STEPS-1];
        sum = {{2{dn_reg[DIV_STEPS-1][31]}}, dn_reg[DIV_STEPS-1]}
            + (dneg_reg[DIV_STEPS-1] ? (34'd0 - {1'b0, q}) : {1'b0, q});
    end

    always_ff @(posedge clk)
    begin
        if (sum[33] && !(sum[32] && sum[31]))
            res_reg <= 32'sh8000_0000;
        else if (!sum[33] && (sum[32] || sum[31]))
            res_reg <= 32'sh7FFF_FFFF;
        else
            res_reg <= sum[31:0];
    end

    assign res = res_reg;

endmodule

>>> rtl/ncl_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncl_emit
// Output stage: assembles up to two triangles per item and strobes them.
// ----------------------------------------------------------------------------
module ncl_emit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vld,
    input  ncl_pkg::side_t        side,
    input  logic signed [31:0]    fx,
    input  logic signed [31:0]    fy,
    input  logic signed [31:0]    sx,
    input  logic signed [31:0]    sy,
    input  logic signed [31:0]    near_z,
    output logic                  done,
    output ncl_pkg::tri_t         tri_out,
    output logic [31:0]           color,
    output logic                  last
);
    import ncl_pkg::*;

    logic        done_reg, done_next;
    logic        last_reg, last_next;
    logic        pend_reg, pend_next;
    tri_t        tri_reg, tri_next;
    tri_t        ptri_reg, ptri_next;
    logic [31:0] color_reg, color_next;
    logic [31:0] pcolor_reg, pcolor_next;
    vtx_t        fv, sv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tri_reg    <= tri_next;
        ptri_reg   <= ptri_next;
        color_reg  <= color_next;
        pcolor_reg <= pcolor_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        fv = '{x: fx, y: fy, z: near_z};
        sv = '{x: sx, y: sy, z: near_z};
        done_next   = 1'b0;
        last_next   = 1'b1;
        pend_next   = 1'b0;
        tri_next    = tri_reg;
        color_next  = color_reg;
        ptri_next   = ptri_reg;
        pcolor_next = pcolor_reg;
        // The busy flag at the input keeps accepted items apart, so a pending second
        // triangle never meets a new item.
        if (vld)
        begin
            color_next = side.color;
            case (side.mode)
                MODE_PASS:
                begin
                    done_next = 1'b1;
                    tri_next  = '{p0: side.q0, p1: side.q1, p2: side.q2};
                end
                MODE_FRONT:
                begin
                    done_next = 1'b1;
                    tri_next  = '{p0: fv, p1: side.q1, p2: sv};
                end
                MODE_BACK:
                begin
                    done_next   = 1'b1;
                    last_next   = 1'b0;
                    pend_next   = 1'b1;
                    tri_next    = '{p0: fv, p1: side.q1, p2: side.q2};
                    ptri_next   = '{p0: sv, p1: side.q2, p2: fv};
                    pcolor_next = side.color;
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
        else if (pend_reg)
        begin
            done_next  = 1'b1;
            tri_next   = ptri_reg;
            color_next = pcolor_reg;
        end
    end

    assign done    = done_reg;
    assign tri_out = tri_reg;
    assign color   = color_reg;
    assign last    = last_reg;

endmodule

>>> rtl/near_plane_triangle_clipper.sv
`timescale 1ns / 1ps
// Output: done rises once an accepted item has passed the set-up stages, cut
// units and output register; a second triangle, where there is one, follows
// in the next cycle. Input: busy is high for the cycle after each accepted
// item, and no item is accepted then. The 33-stage divider in each cut unit
// sets the depth. Reset: near_z returns to 1.0 and the pipeline empties.
// ----------------------------------------------------------------------------
// near_plane_triangle_clipper
// Clips one triangle per item against the plane z = near_z.
// ----------------------------------------------------------------------------
module near_plane_triangle_clipper
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] v0_x,
    input  logic signed [31:0] v0_y,
    input  logic signed [31:0] v0_z,
    input  logic signed [31:0] v1_x,
    input  logic signed [31:0] v1_y,
    input  logic signed [31:0] v1_z,
    input  logic signed [31:0] v2_x,
    input  logic signed [31:0] v2_y,
    input  logic signed [31:0] v2_z,
    input  logic [31:0]        tri_color,
    output logic               done,
    output logic signed [31:0] p0_x,
    output logic signed [31:0] p0_y,
    output logic signed [31:0] p0_z,
    output logic signed [31:0] p1_x,
    output logic signed [31:0] p1_y,
    output logic signed [31:0] p1_z,
    output logic signed [31:0] p2_x,
    output logic signed [31:0] p2_y,
    output logic signed [31:0] p2_z,
    output logic [31:0]        out_color,
    output logic               last_triangle,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ncl_pkg::*;

    logic               busy_reg;
    logic signed [31:0] near_z_reg;
    logic               accept;

    logic               s_vld;
    side_t              s_side;
    lerp_in_t [3:0]     s_cut;
    logic signed [31:0] cut_res [NUM_CUTS];

    logic               dvld_reg  [LERP_LAT];
    side_t              dside_reg [LERP_LAT];

    tri_t               tri_out;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_NEAR_Z) ? near_z_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            near_z_reg <= NEAR_Z_RESET;
        end
        else
        begin
            busy_reg <= accept;
            if (psel && penable && pwrite && (paddr[2] == ADDR_NEAR_Z))
                near_z_reg <= pwdata;
        end
    end

    ncl_setup u_setup
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .v0     ('{x: v0_x, y: v0_y, z: v0_z}),
        .v1     ('{x: v1_x, y: v1_y, z: v1_z}),
        .v2     ('{x: v2_x, y: v2_y, z: v2_z}),
        .color  (tri_color),
        .near_z (near_z_reg),
        .vld    (s_vld),
        .side   (s_side),
        .cut    (s_cut)
    );

    genvar c;
    generate
        for (c = 0; c < NUM_CUTS; c++)
        begin : g_cut
            ncl_lerp u_lerp
            (
                .clk (clk),
                .din (s_cut[c]),
                .res (cut_res[c])
            );
        end
    endgenerate

    // Side data and valid bits ride alongside the cut units.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LERP_LAT; i++)
                dvld_reg[i] <= 1'b0;
        end
        else
        begin
            dvld_reg[0] <= s_vld;
            for (int i = 1; i < LERP_LAT; i++)
                dvld_reg[i] <= dvld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dside_reg[0] <= s_side;
        for (int i = 1; i < LERP_LAT; i++)
            dside_reg[i] <= dside_reg[i-1];
    end

    ncl_emit u_emit
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld     (dvld_reg[LERP_LAT-1]),
        .side    (dside_reg[LERP_LAT-1]),
        .fx      (cut_res[0]),
        .fy      (cut_res[1]),
        .sx      (cut_res[2]),
        .sy      (cut_res[3]),
        .near_z  (near_z_reg),
        .done    (done),
        .tri_out (tri_out),
        .color   (out_color),
        .last    (last_triangle)
    );

    assign p0_x = tri_out.p0.x;
    assign p0_y = tri_out.p0.y;
    assign p0_z = tri_out.p0.z;
    assign p1_x = tri_out.p1.x;
    assign p1_y = tri_out.p1.y;
    assign p1_z = tri_out.p1.z;
    assign p2_x = tri_out.p2.x;
    assign p2_y = tri_out.p2.y;
    assign p2_z = tri_out.p2.z;

endmodule

>>> bench/near_plane_triangle_clipper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// near_plane_triangle_clipper_tb
// Drives triangles into the near-plane clipper under several plane settings,
// predicts every output triangle in the bench and compares each field.
// ----------------------------------------------------------------------------
module near_plane_triangle_clipper_tb;

    import ncl_pkg::*;

    typedef struct {
        logic [31:0] c [9];
        logic [31:0] color;
        logic        last;
    } tri_rec_t;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } pt_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
    logic [31:0]        tri_color;
    logic               done;
    logic signed [31:0] p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
    logic [31:0]        out_color;
    logic               last_triangle;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    tri_rec_t    clipped_q [$];
    logic [31:0] plane_z;
    int          errors;
    int          triangles_in;
    int          triangles_out;
    int          planes_used;

    near_plane_triangle_clipper dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
            errors++;
        end
    endtask

    // Exact edge cut; the offset magnitude is truncated towards zero.
    function automatic longint cut_coord(longint n, longint m, longint num, longint den);
        longint      d;
        logic [95:0] prod;
        logic [95:0] q;
        longint      r;
        begin
            d = m - n;
            prod = 96'((d < 0) ? -d : d) * 96'(num);
            q = prod / 96'(den);
            r = (d < 0) ? n - longint'(q) : n + longint'(q);
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return r;
        end
    endfunction

    function automatic pt_t cut_edge(pt_t a, pt_t b);
        pt_t n, m, r;
        begin
            n = (a.z < b.z) ? a : b;
            m = (a.z < b.z) ? b : a;
            r.x = cut_coord(n.x, m.x, longint'($signed(plane_z)) - n.z, m.z - n.z);
            r.y = cut_coord(n.y, m.y, longint'($signed(plane_z)) - n.z, m.z - n.z);
            r.z = longint'($signed(plane_z));
            return r;
        end
    endfunction

    function automatic tri_rec_t make_tri(pt_t a, pt_t b, pt_t c, logic [31:0] col,
                                          logic last);
        tri_rec_t t;
        begin
            t.c[0] = a.x[31:0]; t.c[1] = a.y[31:0]; t.c[2] = a.z[31:0];
            t.c[3] = b.x[31:0]; t.c[4] = b.y[31:0]; t.c[5] = b.z[31:0];
            t.c[6] = c.x[31:0]; t.c[7] = c.y[31:0]; t.c[8] = c.z[31:0];
            t.color = col;
            t.last = last;
            return t;
        end
    endfunction

    task automatic predict_clip(input logic [31:0] vin [9], input logic [31:0] col);
        pt_t v [3];
        pt_t base, o1, o2, f, s;
        logic bk [3];
        begin
            for (int i = 0; i < 3; i++)
            begin
                v[i].x = longint'($signed(vin[3*i]));
                v[i].y = longint'($signed(vin[3*i+1]));
                v[i].z = longint'($signed(vin[3*i+2]));
                bk[i] = v[i].z <= longint'($signed(plane_z));
            end
            if (bk[0] && bk[1] && bk[2])
                return;
            if (bk[0] == bk[1] && bk[1] == bk[2])
            begin
                clipped_q.push_back(make_tri(v[0], v[1], v[2], col, 1'b1));
                return;
            end
            if (bk[1] == bk[2])
            begin
                base = v[0]; o1 = v[1]; o2 = v[2];
                f = cut_edge(v[0], v[1]); s = cut_edge(v[0], v[2]);
            end
            else if (bk[0] == bk[2])
            begin
                base = v[1]; o1 = v[0]; o2 = v[2];
                f = cut_edge(v[0], v[1]); s = cut_edge(v[1], v[2]);
            end
            else
            begin
                base = v[2]; o1 = v[0]; o2 = v[1];
                f = cut_edge(v[0], v[2]); s = cut_edge(v[1], v[2]);
            end
            if (base.z <= longint'($signed(plane_z)))
            begin
                clipped_q.push_back(make_tri(f, o1, o2, col, 1'b0));
                clipped_q.push_back(make_tri(s, o2, f, col, 1'b1));
            end
            else
                clipped_q.push_back(make_tri(f, base, s, col, 1'b1));
        end
    endtask

    // start is left high after the accepting edge; busy keeps that cycle from
    // taking a second item, and a drain or the next call with a gap lowers it.
    task automatic send_triangle(input logic [31:0] vin [9], input logic [31:0] col);
        int gap;
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start <= 1'b1;
            {v0_x, v0_y, v0_z} <= {vin[0], vin[1], vin[2]};
            {v1_x, v1_y, v1_z} <= {vin[3], vin[4], vin[5]};
            {v2_x, v2_y, v2_z} <= {vin[6], vin[7], vin[8]};
            tri_color <= col;
            @(posedge clk);
            while (busy) @(posedge clk);
            predict_clip(vin, col);
            triangles_in++;
        end
    endtask

    task automatic drain_pipeline();
        int guard;
        begin
            guard = 0;
            start <= 1'b0;
            while (clipped_q.size() != 0 && guard < 5000)
            begin
                @(posedge clk);
                guard++;
            end
            // A dropped triangle may still be in flight.
            repeat (LERP_LAT + 10) @(posedge clk);
        end
    endtask

    task automatic write_plane(input logic [31:0] value);
        begin
            drain_pipeline();
            psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
            plane_z = value;
            planes_used++;
            @(posedge clk);
            // Read back to confirm the register holds the new plane.
            psel <= 1'b1;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (prdata !== value) report_mismatch("near_z readback", prdata, value);
            psel <= 1'b0; penable <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_z(logic [31:0] pz);
        logic [31:0] r;
        begin
            case ($urandom_range(0, 5))
                0: r = $urandom;
                1: r = pz;
                2: r = pz + $urandom_range(0, 255) - 128;
                default: r = pz + ($urandom_range(0, 32'h7_ffff) - 32'h4_0000);
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] rand_xy();
        return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'hf_ffff) - 32'h8_0000;
    endfunction

    task automatic test_directed();
        logic [31:0] vin [9];
        logic [31:0] xv [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        begin
            // All behind, all in front, on the plane, and each lone vertex on both sides.
            for (int pat = 0; pat < 8; pat++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vin[3*i]   = xv[(pat + i) % 4];
                    vin[3*i+1] = xv[(pat + i + 1) % 4];
                    vin[3*i+2] = pat[i] ? plane_z + 32'h1_0000 : plane_z - 32'h2_0000;
                end
                send_triangle(vin, {pat[7:0], 24'h5a_a5c3});
            end
            for (int i = 0; i < 9; i++) vin[i] = (i % 3 == 2) ? plane_z : 32'h1234;
            send_triangle(vin, 32'hffff_ffff);
            // Extreme depth span together with extreme coordinates.
            for (int k = 0; k < 6; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vin[3*i]   = xv[(k + i) % 4];
                    vin[3*i+1] = xv[(k + 2*i) % 4];
                    vin[3*i+2] = (i == k % 3) ^ k[0] ? 32'h7fff_ffff : 32'h8000_0000;
                end
                send_triangle(vin, 32'h0);
            end
        end
    endtask

    task automatic test_random(input int count);
        logic [31:0] vin [9];
        begin
            for (int n = 0; n < count; n++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vin[3*i]   = rand_xy();
                    vin[3*i+1] = rand_xy();
                    vin[3*i+2] = rand_z(plane_z);
                end
                send_triangle(vin, $urandom);
            end
        end
    endtask

    task automatic test_plane_settings();
        begin
            write_plane(32'h8000_0000);
            test_directed();
            test_random(150);
            write_plane(32'h7fff_ffff);
            test_directed();
            test_random(150);
            write_plane(32'h0);
            test_random(200);
            write_plane($urandom);
            test_random(200);
            write_plane(32'hfff0_0000);
            test_random(200);
        end
    endtask

    // Each triangle is flagged by done for one cycle only.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (clipped_q.size() == 0)
            begin
                $display("MISMATCH unexpected triangle at %0t", $realtime);
                errors++;
            end
            else
            begin
                tri_rec_t want;
                logic [31:0] got [9];
                want = clipped_q.pop_front();
                got = '{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z};
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.c[i])
                        report_mismatch($sformatf("p%0d coord %0d", i / 3, i % 3),
                                        got[i], want.c[i]);
                if (out_color !== want.color)
                    report_mismatch("out_color", out_color, want.color);
                if (last_triangle !== want.last)
                    report_mismatch("last_triangle", 32'(last_triangle), 32'(want.last));
                triangles_out++;
            end
        end
    end

    initial
    begin
        #50ms;
        $display("near_plane_triangle_clipper_tb: done, errors");
        $finish;
    end

    initial
    begin
        errors = 0; triangles_in = 0; triangles_out = 0; planes_used = 0;
        plane_z = NEAR_Z_RESET;
        rst_n = 1'b0; start = 1'b0;
        {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} = '0;
        tri_color = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(200);
        test_plane_settings();
        drain_pipeline();
        if (clipped_q.size() != 0)
        begin
            $display("MISMATCH %0d triangles never appeared", clipped_q.size());
            errors++;
        end
        $display("Sent %0d triangles under %0d plane settings plus reset value;",
                 triangles_in, planes_used);
        $display("checked %0d clipped triangles.", triangles_out);
        if (errors == 0)
            $display("near_plane_triangle_clipper_tb: done, clean");
        else
            $display("near_plane_triangle_clipper_tb: done, errors");
        $finish;
    end

endmodule
